/* rtl/core/css_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// css_pkg
// Shared command and result codes and field widths of the command slot
// scheduler.
// ----------------------------------------------------------------------------
package css_pkg;

   localparam int CMD_W  = 2;
   localparam int KIND_W = 2;

   localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RUN_ONE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DRAIN    = 2'd2;

   localparam logic [KIND_W-1:0] KIND_GRANTED   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COMPLETED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY     = 2'd2;

endpackage : css_pkg
`default_nettype wire

/* rtl/core/css_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// css_req_if
// Request channel of the command slot scheduler: command code and task word.
// ----------------------------------------------------------------------------
interface css_req_if #(
   parameter int TAG_BITS = 32
);
   logic                       valid;
   logic                       ready;
   logic [css_pkg::CMD_W-1:0]  cmd;
   logic [TAG_BITS-1:0]        task_tag;

   modport source (output valid, output cmd, output task_tag, input ready);
   modport sink   (input valid, input cmd, input task_tag, output ready);
endinterface : css_req_if
`default_nettype wire

/* rtl/core/css_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// css_rsp_if
// Response channel of the command slot scheduler: result kind, slot, task
// word and last mark.
// ----------------------------------------------------------------------------
interface css_rsp_if #(
   parameter int SLOT_W   = 4,
   parameter int TAG_BITS = 32
);
   logic                       valid;
   logic                       ready;
   logic [css_pkg::KIND_W-1:0] kind;
   logic [SLOT_W-1:0]          slot;
   logic [TAG_BITS-1:0]        stored_tag;
   logic                       last;

   modport source (output valid, output kind, output slot, output stored_tag,
                   output last, input ready);
   modport sink   (input valid, input kind, input slot, input stored_tag,
                   input last, output ready);
endinterface : css_rsp_if
`default_nettype wire

/* rtl/core/command_slot_scheduler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// command_slot_scheduler
// Slot manager: LIFO free list of slot indices plus FIFO ring of waiting
// slots, with a task word stored per slot.
// Schedule: free list read, then grant; with no free slot, the waiting slots
// are first completed until the ring is empty. Run-one and each drained
// completion: ring read, task word read, result, as the memory reads chain.
// Empty ring: a single empty result. A new request is taken the cycle after
// the last result of the previous one is registered.
// Reset (synchronous) restores the free list at once through per-entry
// written bits; no clearing pass.
// ----------------------------------------------------------------------------
module command_slot_scheduler #(
   parameter int SLOTS    = 16,
   parameter int TAG_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   css_req_if.sink   req_ch,
   css_rsp_if.source rsp_ch
);

   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int RING_DEPTH = SLOTS + 1;
   localparam int RPTR_W     = $clog2(RING_DEPTH);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_CPL_RD    = 3'd1;
   localparam logic [2:0] ST_CPL_TAG   = 3'd2;
   localparam logic [2:0] ST_CPL_OUT   = 3'd3;
   localparam logic [2:0] ST_GRANT_RD  = 3'd4;
   localparam logic [2:0] ST_GRANT_OUT = 3'd5;
   localparam logic [2:0] ST_EMPTY     = 3'd6;

   logic [2:0]                 state_ff, state_in;
   logic [css_pkg::CMD_W-1:0]  mode_ff, mode_in;
   logic [TAG_BITS-1:0]        tag_ff, tag_in;
   logic [CNT_W-1:0]           free_count_ff, free_count_in;
   logic [RPTR_W-1:0]          head_ff, head_in;
   logic [RPTR_W-1:0]          tail_ff, tail_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;

   logic [SLOT_W-1:0]          free_mem [SLOTS];
   logic [SLOTS-1:0]           free_vld_ff;
   logic [SLOT_W-1:0]          ring_mem [RING_DEPTH];
   logic [TAG_BITS-1:0]        tag_mem [SLOTS];

   logic [SLOT_W-1:0]          free_rd_ff;
   logic                       free_rd_vld_ff;
   logic [SLOT_W-1:0]          free_rd_idx_ff;
   logic [SLOT_W-1:0]          ring_rd_ff;
   logic [TAG_BITS-1:0]        tag_rd_ff;

   logic                       free_rd_en, free_wr_en;
   logic [SLOT_W-1:0]          free_rd_addr, free_wr_addr;
   logic                       ring_rd_en, ring_wr_en;
   logic                       tag_rd_en, tag_wr_en;

   logic                       rsp_valid_ff;
   logic [css_pkg::KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]          rsp_slot_ff, rsp_slot_in;
   logic [TAG_BITS-1:0]        rsp_tag_ff, rsp_tag_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_load;

   logic                       ring_empty;
   logic                       out_free;
   logic [RPTR_W-1:0]          head_next, tail_next;
   logic [CNT_W-1:0]           free_top;
   logic [SLOT_W-1:0]          grant_slot;
   logic [RPTR_W:0]            ring_occ;
   logic [RPTR_W+1:0]          held_total;

   assign ring_empty = (head_ff == tail_ff);
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign head_next  = (head_ff == RPTR_W'(SLOTS)) ? '0 : head_ff + 1'b1;
   assign tail_next  = (tail_ff == RPTR_W'(SLOTS)) ? '0 : tail_ff + 1'b1;
   assign free_top   = free_count_ff - 1'b1;
   assign grant_slot = free_rd_vld_ff ? free_rd_ff : free_rd_idx_ff;

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = rsp_kind_ff;
   assign rsp_ch.slot       = rsp_slot_ff;
   assign rsp_ch.stored_tag = rsp_tag_ff;
   assign rsp_ch.last       = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      tag_in        = tag_ff;
      free_count_in = free_count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      slot_in       = slot_ff;
      free_rd_en    = 1'b0;
      free_rd_addr  = free_top[SLOT_W-1:0];
      free_wr_en    = 1'b0;
      free_wr_addr  = free_count_ff[SLOT_W-1:0];
      ring_rd_en    = 1'b0;
      ring_wr_en    = 1'b0;
      tag_rd_en     = 1'b0;
      tag_wr_en     = 1'b0;
      rsp_load      = 1'b0;
      rsp_kind_in   = css_pkg::KIND_EMPTY;
      rsp_slot_in   = '0;
      rsp_tag_in    = '0;
      rsp_last_in   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               case (req_ch.cmd)
                  css_pkg::CMD_SCHEDULE: begin
                     mode_in = req_ch.cmd;
                     tag_in  = req_ch.task_tag;
                     if (free_count_ff != '0) begin
                        state_in = ST_GRANT_RD;
                     end else if (!ring_empty) begin
                        state_in = ST_CPL_RD;
                     end else begin
                        state_in = ST_EMPTY;
                     end
                  end
                  css_pkg::CMD_RUN_ONE, css_pkg::CMD_DRAIN: begin
                     mode_in  = req_ch.cmd;
                     state_in = ring_empty ? ST_EMPTY : ST_CPL_RD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CPL_RD: begin
            ring_rd_en = 1'b1;
            head_in    = head_next;
            state_in   = ST_CPL_TAG;
         end
         ST_CPL_TAG: begin
            slot_in   = ring_rd_ff;
            tag_rd_en = 1'b1;
            state_in  = ST_CPL_OUT;
         end
         ST_CPL_OUT: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_kind_in = css_pkg::KIND_COMPLETED;
               rsp_slot_in = slot_ff;
               rsp_tag_in  = tag_rd_ff;
               rsp_last_in = (mode_ff == css_pkg::CMD_RUN_ONE) ||
                             ((mode_ff == css_pkg::CMD_DRAIN) && ring_empty);
               if (free_count_ff < CNT_W'(SLOTS)) begin
                  free_wr_en    = 1'b1;
                  free_count_in = free_count_ff + 1'b1;
               end
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end else if (ring_empty) begin
                  state_in = ST_GRANT_RD;
               end else begin
                  state_in = ST_CPL_RD;
               end
            end
         end
         ST_GRANT_RD: begin
            free_rd_en    = 1'b1;
            free_count_in = free_top;
            state_in      = ST_GRANT_OUT;
         end
         ST_GRANT_OUT: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_kind_in = css_pkg::KIND_GRANTED;
               rsp_slot_in = grant_slot;
               rsp_tag_in  = tag_ff;
               tag_wr_en   = 1'b1;
               ring_wr_en  = 1'b1;
               tail_in     = tail_next;
               state_in    = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_count_ff <= CNT_W'(SLOTS);
         head_ff       <= '0;
         tail_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         free_vld_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (free_wr_en) begin
            free_vld_ff[free_wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      tag_ff  <= tag_in;
      slot_ff <= slot_in;
      if (rsp_load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_slot_ff <= rsp_slot_in;
         rsp_tag_ff  <= rsp_tag_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   // free list memory; unwritten entries read as their own index
   always_ff @(posedge clock) begin
      if (free_wr_en) begin
         free_mem[free_wr_addr] <= slot_ff;
      end
      if (free_rd_en) begin
         free_rd_ff     <= free_mem[free_rd_addr];
         free_rd_vld_ff <= free_vld_ff[free_rd_addr];
         free_rd_idx_ff <= free_rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_wr_en) begin
         ring_mem[tail_ff] <= grant_slot;
      end
      if (ring_rd_en) begin
         ring_rd_ff <= ring_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (tag_wr_en) begin
         tag_mem[grant_slot] <= tag_ff;
      end
      if (tag_rd_en) begin
         tag_rd_ff <= tag_mem[ring_rd_ff];
      end
   end

   assign ring_occ = (tail_ff >= head_ff) ?
                     ((RPTR_W+1)'(tail_ff) - (RPTR_W+1)'(head_ff)) :
                     ((RPTR_W+1)'(tail_ff) + (RPTR_W+1)'(RING_DEPTH) -
                      (RPTR_W+1)'(head_ff));
   assign held_total = (RPTR_W+2)'(free_count_ff) + (RPTR_W+2)'(ring_occ);

   a_slots_conserved: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (held_total == (RPTR_W+2)'(SLOTS)))
      else $error("free and waiting slots do not add up");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CNT_W'(SLOTS))
      else $error("free count above slot count");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (state_ff == ST_IDLE))
      else $error("last result did not end the request");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !rsp_last_in) |=> (state_ff != ST_IDLE))
      else $error("request ended without last result");

   a_grant_has_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GRANT_RD) |-> (free_count_ff != '0))
      else $error("grant with empty free list");

endmodule : command_slot_scheduler
`default_nettype wire
